>>> rtl/core/mstt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-touch slot tracker package
// Shared widths, codes, command/status structs and the distance function.
// ----------------------------------------------------------------------------
package mstt_pkg;

  // Field widths
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TAPS_W     = 8;
  localparam int unsigned SLOTIDX_W  = 4;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned DIST_W     = 2 * COORD_W;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Defaults
  localparam int unsigned DEF_SLOT_COUNT = 10;
  localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(10);
  localparam logic [WIN_W-1:0]  WIN_RESET    = WIN_W'(500);
  localparam logic [DIST_W-1:0] THR_SQ_RESET = DIST_W'(100);
  localparam logic [TAPS_W-1:0] TAPS_MAX     = TAPS_W'(255);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW     = CFG_IDX_W'(1);

  // Event codes
  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // Slot read address source
  typedef enum logic [1:0] {
    RD_SCAN = 2'd0,
    RD_FREE = 2'd1,
    RD_BEST = 2'd2
  } rd_sel_e;

  // Controller -> datapath
  typedef struct packed {
    logic    in_ready;
    logic    scan_en;
    logic    drag_sq;
    logic    do_start;
    logic    do_update;
    logic    res_none;
    logic    push;
    rd_sel_e rd_sel;
  } mstt_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic  in_fire;
    kind_e kind;
    logic  scan_last;
    logic  out_free;
  } mstt_status_t;

  // Squared absolute difference of two coordinates
  function automatic logic [DIST_W-1:0] sq_diff(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return DIST_W'(d) * DIST_W'(d);
  endfunction

endpackage

>>> rtl/core/mstt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-touch slot tracker channel interfaces
// Touch event, result and configuration write channels (valid/ready).
// ----------------------------------------------------------------------------

// Touch event channel
interface mstt_evt_if import mstt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [COORD_W-1:0]  pos_x;
  logic [COORD_W-1:0]  pos_y;
  logic [TIME_W-1:0]   time_now;

  modport source (output valid, kind, pos_x, pos_y, time_now, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, time_now, output ready);
endinterface

// Result channel
interface mstt_res_if import mstt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 slot_found;
  logic [SLOTIDX_W-1:0] slot_index;
  logic                 is_dragging;
  logic [TAPS_W-1:0]    taps;

  modport source (output valid, slot_found, slot_index, is_dragging, taps, input ready);
  modport sink   (input valid, slot_found, slot_index, is_dragging, taps, output ready);
endinterface

// Configuration write channel
interface mstt_cfg_if import mstt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/multi_touch_slot_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-touch slot tracker
// Assigns touch events to contact slots, tracks drag and tap state.
// ----------------------------------------------------------------------------
// Sequence: a start event passes the dispatch, start and done states before its
//   result is registered; a move/end event instead runs the one-slot-per-cycle
//   nearest-contact scan through a shared squared-distance stage, then the flush,
//   drag test and update states before done.
// Flow: one event at a time; the next transfer is taken once the result enters
//   the output register, later while the result stalls.
// Reset: asynchronous, active low; all slots inactive and zero, threshold 10,
//   tap window 500, no result pending.
module multi_touch_slot_tracker import mstt_pkg::*; #(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mstt_evt_if.sink   evt_i,
  mstt_res_if.source res_o,
  mstt_cfg_if.sink   cfg_i
);

  mstt_cmd_t    cmd;
  mstt_status_t st;

  mstt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  mstt_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_i),
    .res_o  (res_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .st_o   (st)
  );

  // One event in flight: no new transfer right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.valid && evt_i.ready |=> !evt_i.ready)
    else $error("event accepted twice in a row");

  // A found slot lies within the slot range
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.slot_found |->
      {1'b0, res_o.slot_index} < (SLOTIDX_W + 1)'(SLOT_COUNT))
    else $error("slot index out of range");

  // No slot found: all result fields zero
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.slot_found |->
      res_o.slot_index == '0 && !res_o.is_dragging && res_o.taps == '0)
    else $error("empty result carries data");

endmodule

>>> rtl/core/mstt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-touch slot tracker controller
// Sequences accept, slot start or scan, drag test, slot update and result transfer.
// ----------------------------------------------------------------------------
module mstt_ctrl import mstt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mstt_status_t st_i,
  output mstt_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_START    = 8'b0000_0100,
    S_SCAN     = 8'b0000_1000,
    S_FLUSH    = 8'b0001_0000,
    S_DRAG_SQ  = 8'b0010_0000,
    S_UPDATE   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{rd_sel: RD_SCAN, default: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (st_i.in_fire) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (st_i.kind) inside
          KIND_START: state_d = S_START;
          KIND_MOVE, KIND_END: state_d = S_SCAN;
          default: begin
            // unused code: empty result
            cmd_o.res_none = 1'b1;
            state_d        = S_DONE;
          end
        endcase
      end
      S_START: begin
        cmd_o.do_start = 1'b1;
        cmd_o.rd_sel   = RD_FREE;
        state_d        = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        cmd_o.rd_sel  = RD_SCAN;
        if (st_i.scan_last) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        // last compare of the scan pipe
        state_d = S_DRAG_SQ;
      end
      S_DRAG_SQ: begin
        cmd_o.drag_sq = 1'b1;
        cmd_o.rd_sel  = RD_BEST;
        state_d       = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.do_update = 1'b1;
        cmd_o.rd_sel    = RD_BEST;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/mstt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-touch slot tracker datapath
// Slot state, config registers, distance pipe, nearest search and result.
// ----------------------------------------------------------------------------
module mstt_dp import mstt_pkg::*; #(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mstt_evt_if.sink     evt_i,
  mstt_res_if.source   res_o,
  mstt_cfg_if.sink     cfg_i,
  input  mstt_cmd_t    cmd_i,
  output mstt_status_t st_o
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Latched event
  kind_e              kind_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [TIME_W-1:0]  now_q;

  // Config
  logic [WIN_W-1:0]  win_q;
  logic [DIST_W-1:0] thr_sq_q;

  // Slot state
  logic [SLOT_COUNT-1:0] act_q, drag_q;
  logic [TAPS_W-1:0]     taps_q [SLOT_COUNT];
  logic [COORD_W-1:0]    sx_q [SLOT_COUNT];
  logic [COORD_W-1:0]    sy_q [SLOT_COUNT];
  logic [COORD_W-1:0]    cx_q [SLOT_COUNT];
  logic [COORD_W-1:0]    cy_q [SLOT_COUNT];
  logic [TIME_W-1:0]     et_q [SLOT_COUNT];

  // Scan pipe and nearest tracking
  logic [IDX_W-1:0]  scan_cnt_q;
  logic              s1_valid_q, s1_act_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic [DIST_W-1:0] sq_x_q, sq_y_q;
  logic              found_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [DIST_W:0]   best_d_q;

  // Result staging and output register
  logic                 res_found_q, res_drag_q;
  logic [IDX_W-1:0]     res_idx_q;
  logic [TAPS_W-1:0]    res_taps_q;
  logic                 out_valid_q;
  logic                 out_found_q, out_drag_q;
  logic [SLOTIDX_W-1:0] out_idx_q;
  logic [TAPS_W-1:0]    out_taps_q;

  logic               in_fire;
  logic [IDX_W-1:0]   free_idx, rd_idx;
  logic [COORD_W-1:0] ax, ay, bx, by;
  logic [DIST_W:0]    dist_sum;
  logic               closer, beyond, drag_new, tap_hit;
  logic [TIME_W:0]    tap_limit;
  logic [TAPS_W-1:0]  taps_new;

  assign in_fire     = evt_i.valid && evt_i.ready;
  assign evt_i.ready = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;

  assign st_o.in_fire   = in_fire;
  assign st_o.kind      = kind_q;
  assign st_o.scan_last = (scan_cnt_q == IDX_W'(SLOT_COUNT - 1));
  assign st_o.out_free  = !out_valid_q || res_o.ready;

  // First inactive slot, last slot when all are in use
  always_comb begin
    free_idx = IDX_W'(SLOT_COUNT - 1);
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!act_q[i]) free_idx = IDX_W'(i);
    end
  end

  // Slot read address
  always_comb begin
    case (cmd_i.rd_sel)
      RD_SCAN: rd_idx = scan_cnt_q;
      RD_FREE: rd_idx = free_idx;
      RD_BEST: rd_idx = best_idx_q;
      default: rd_idx = scan_cnt_q;
    endcase
  end

  // Squarer operands: scan measures event to current point, drag test
  // measures start point to new (move) or held (end) current point
  always_comb begin
    if (cmd_i.drag_sq) begin
      ax = (kind_q == KIND_MOVE) ? x_q : cx_q[rd_idx];
      ay = (kind_q == KIND_MOVE) ? y_q : cy_q[rd_idx];
      bx = sx_q[rd_idx];
      by = sy_q[rd_idx];
    end else begin
      ax = cx_q[rd_idx];
      ay = cy_q[rd_idx];
      bx = x_q;
      by = y_q;
    end
  end

  assign dist_sum = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign closer   = s1_valid_q && s1_act_q && (!found_q || (dist_sum < best_d_q));
  assign beyond   = dist_sum > {1'b0, thr_sq_q};
  assign drag_new = drag_q[rd_idx] || beyond;

  // Tap test, sum kept one bit wider so it never wraps
  assign tap_limit = {1'b0, et_q[rd_idx]} + (TIME_W + 1)'(win_q);
  assign tap_hit   = {1'b0, now_q} < tap_limit;
  always_comb begin
    if (!tap_hit)                       taps_new = '0;
    else if (taps_q[rd_idx] == TAPS_MAX) taps_new = TAPS_MAX;
    else                                taps_new = taps_q[rd_idx] + TAPS_W'(1);
  end

  // Event latch
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_e'(evt_i.kind);
      x_q    <= evt_i.pos_x;
      y_q    <= evt_i.pos_y;
      now_q  <= evt_i.time_now;
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= WIN_RESET;
      thr_sq_q <= THR_SQ_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_DRAG_THRESHOLD: begin
          thr_sq_q <= DIST_W'(cfg_i.data[THR_W-1:0]) * DIST_W'(cfg_i.data[THR_W-1:0]);
        end
        CFG_TAP_WINDOW: win_q <= cfg_i.data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Distance stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en || cmd_i.drag_sq) begin
      sq_x_q   <= sq_diff(ax, bx);
      sq_y_q   <= sq_diff(ay, by);
      s1_act_q <= act_q[rd_idx];
      s1_idx_q <= scan_cnt_q;
    end
  end

  // Scan control and nearest tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      s1_valid_q <= 1'b0;
      found_q    <= 1'b0;
      best_idx_q <= '0;
      best_d_q   <= '0;
    end else begin
      s1_valid_q <= cmd_i.scan_en;
      if (in_fire) begin
        scan_cnt_q <= '0;
        found_q    <= 1'b0;
      end else begin
        if (cmd_i.scan_en) scan_cnt_q <= scan_cnt_q + IDX_W'(1);
        // strict compare: lowest index wins ties
        if (closer) begin
          found_q    <= 1'b1;
          best_idx_q <= s1_idx_q;
          best_d_q   <= dist_sum;
        end
      end
    end
  end

  // Slot state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= '0;
      drag_q <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        taps_q[i] <= '0;
        sx_q[i]   <= '0;
        sy_q[i]   <= '0;
        cx_q[i]   <= '0;
        cy_q[i]   <= '0;
        et_q[i]   <= '0;
      end
    end else if (cmd_i.do_start) begin
      taps_q[rd_idx] <= taps_new;
      sx_q[rd_idx]   <= x_q;
      sy_q[rd_idx]   <= y_q;
      cx_q[rd_idx]   <= x_q;
      cy_q[rd_idx]   <= y_q;
      act_q[rd_idx]  <= 1'b1;
      drag_q[rd_idx] <= 1'b0;
    end else if (cmd_i.do_update && found_q) begin
      drag_q[rd_idx] <= drag_new;
      cx_q[rd_idx]   <= x_q;
      cy_q[rd_idx]   <= y_q;
      if (kind_q == KIND_END) begin
        act_q[rd_idx] <= 1'b0;
        et_q[rd_idx]  <= now_q;
      end
    end
  end

  // Result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_start) begin
      res_found_q <= 1'b1;
      res_idx_q   <= rd_idx;
      res_drag_q  <= 1'b0;
      res_taps_q  <= taps_new;
    end else if (cmd_i.do_update && found_q) begin
      res_found_q <= 1'b1;
      res_idx_q   <= rd_idx;
      res_drag_q  <= drag_new;
      res_taps_q  <= taps_q[rd_idx];
    end else if (cmd_i.do_update || cmd_i.res_none) begin
      res_found_q <= 1'b0;
      res_idx_q   <= '0;
      res_drag_q  <= 1'b0;
      res_taps_q  <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_found_q <= res_found_q;
      out_idx_q   <= SLOTIDX_W'(res_idx_q);
      out_drag_q  <= res_drag_q;
      out_taps_q  <= res_taps_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.slot_found  = out_found_q;
  assign res_o.slot_index  = out_idx_q;
  assign res_o.is_dragging = out_drag_q;
  assign res_o.taps        = out_taps_q;

endmodule
